### rtl/oja_rule_weight_update_top_defines.svh
// ----------------------------------------------------------------------------
// Oja weight update - assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef OJA_RULE_WEIGHT_UPDATE_TOP_DEFINES_SVH
`define OJA_RULE_WEIGHT_UPDATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent holds -> consequent holds in the same cycle
`define OWU_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("owu check failed: same-cycle implication");

// antecedent holds -> consequent holds in the next cycle
`define OWU_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("owu check failed: next-cycle implication");

`else

`define OWU_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define OWU_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

### rtl/owu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owu_pkg
// Types, constants and helpers shared by the Oja weight update block.
// ----------------------------------------------------------------------------
package owu_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int FRAC_BITS   = 12;
    localparam int RATE_BITS   = 16;
    localparam int NUM_W       = 4;

    localparam int PROD_W  = 2 * VALUE_WIDTH;      // value x value product
    localparam int DWP_W   = RATE_BITS + VALUE_WIDTH + 1; // rate x value product
    localparam int SAT_W   = 2 * VALUE_WIDTH + 4;  // headroom for sums and rounding

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (VALUE_WIDTH > RATE_BITS) ? VALUE_WIDTH : RATE_BITS;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [SAT_W-1:0]       wide_t;
    typedef logic        [RATE_BITS-1:0]   rate_t;
    typedef logic        [CFG_IDX_W-1:0]   cfg_idx_t;
    typedef logic        [CFG_DATA_W-1:0]  cfg_data_t;

    // register map
    localparam cfg_idx_t REG_LEARN_RATE    = 3'd0;
    localparam cfg_idx_t REG_INIT_WEIGHT0  = 3'd1;

    localparam rate_t  LEARN_RATE_RESET  = rate_t'(655);
    localparam value_t INIT_WEIGHT_RESET = value_t'(1 << FRAC_BITS);

    // half an LSB for round-half-up
    localparam wide_t FRAC_HALF = wide_t'(1) <<< (FRAC_BITS - 1);
    localparam wide_t RATE_HALF = wide_t'(1) <<< (RATE_BITS - 1);

    localparam wide_t VAL_MAX = (wide_t'(1) <<< (VALUE_WIDTH - 1)) - wide_t'(1);
    localparam wide_t VAL_MIN = -(wide_t'(1) <<< (VALUE_WIDTH - 1));

    typedef struct packed {
        value_t sample0;
        value_t sample1;
        value_t sample2;
        value_t sample3;
    } sample_t;

    typedef struct packed {
        value_t projection;
        value_t weight_out0;
        value_t weight_out1;
        value_t weight_out2;
        value_t weight_out3;
    } result_t;

    // per-step strobes from the sequencer to the lanes
    typedef struct packed {
        logic load_sample;
        logic calc_vw;
        logic calc_term;
        logic update;
    } lane_ctrl_t;

    function automatic value_t sat_value(input wide_t x);
        value_t r;
        if (x > VAL_MAX)
            r = value_t'(VAL_MAX);
        else if (x < VAL_MIN)
            r = value_t'(VAL_MIN);
        else
            r = value_t'(x);
        return r;
    endfunction

endpackage

### rtl/owu_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owu_lane
// One weight lane: holds its weight, forms w*z, then the Oja correction.
// ----------------------------------------------------------------------------
module owu_lane
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  owu_pkg::lane_ctrl_t  ctrl,
    input  owu_pkg::value_t      sample,
    input  owu_pkg::value_t      proj,
    input  owu_pkg::rate_t       learn_rate,
    input  logic                 load_en,
    input  owu_pkg::value_t      load_val,
    output owu_pkg::prod_t       prod,
    output owu_pkg::value_t      weight,
    output owu_pkg::value_t      weight_upd
);

    owu_pkg::value_t weight_reg;
    owu_pkg::value_t z_reg;
    owu_pkg::prod_t  prod_reg;
    owu_pkg::prod_t  pvw_reg;
    owu_pkg::prod_t  pt_reg;

    owu_pkg::wide_t  vw_wide;
    owu_pkg::value_t vw;
    owu_pkg::value_t d;
    owu_pkg::prod_t  pt_next;
    owu_pkg::value_t t;
    logic signed [owu_pkg::DWP_W-1:0] dw_prod;
    owu_pkg::wide_t  dw_wide;
    owu_pkg::value_t weight_next;

    always_comb
    begin
        vw_wide = (owu_pkg::wide_t'(pvw_reg) + owu_pkg::FRAC_HALF) >>> owu_pkg::FRAC_BITS;
        vw      = owu_pkg::sat_value(vw_wide);
        d       = owu_pkg::sat_value(owu_pkg::wide_t'(z_reg) - owu_pkg::wide_t'(vw));
        pt_next = owu_pkg::prod_t'(proj) * owu_pkg::prod_t'(d);

        t       = owu_pkg::sat_value((owu_pkg::wide_t'(pt_reg) + owu_pkg::FRAC_HALF)
                                     >>> owu_pkg::FRAC_BITS);
        // rate is unsigned: zero-extend before the signed multiply
        dw_prod = $signed({{(owu_pkg::DWP_W - owu_pkg::RATE_BITS){1'b0}}, learn_rate})
                  * (owu_pkg::DWP_W)'(t);
        dw_wide = (owu_pkg::wide_t'(dw_prod) + owu_pkg::RATE_HALF) >>> owu_pkg::RATE_BITS;
        weight_next = owu_pkg::sat_value(owu_pkg::wide_t'(weight_reg) + dw_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= owu_pkg::INIT_WEIGHT_RESET;
        end
        else if (load_en)
        begin
            weight_reg <= load_val;
        end
        else if (ctrl.update)
        begin
            weight_reg <= weight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_sample)
        begin
            z_reg    <= sample;
            prod_reg <= owu_pkg::prod_t'(weight_reg) * owu_pkg::prod_t'(sample);
        end
        if (ctrl.calc_vw)
        begin
            pvw_reg <= owu_pkg::prod_t'(proj) * owu_pkg::prod_t'(weight_reg);
        end
        if (ctrl.calc_term)
        begin
            pt_reg <= pt_next;
        end
    end

    assign prod       = prod_reg;
    assign weight     = weight_reg;
    assign weight_upd = weight_next;

endmodule

### rtl/owu_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owu_merge
// Sums the lane products and rounds them into the projection v.
// ----------------------------------------------------------------------------
module owu_merge
(
    input  logic             clk,
    input  logic             en,
    input  owu_pkg::prod_t   prod [owu_pkg::NUM_W],
    output owu_pkg::value_t  proj
);

    owu_pkg::value_t v_reg;
    owu_pkg::wide_t  sum;

    always_comb
    begin
        sum = owu_pkg::FRAC_HALF;
        for (int i = 0; i < owu_pkg::NUM_W; i++)
        begin
            sum = sum + owu_pkg::wide_t'(prod[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= owu_pkg::sat_value(sum >>> owu_pkg::FRAC_BITS);
        end
    end

    assign proj = v_reg;

endmodule

### rtl/oja_rule_weight_update_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oja_rule_weight_update_top
// Oja-rule learner for one linear neuron with four Q3.12 inputs.
// ----------------------------------------------------------------------------
// Each transaction on the input channel carries one sample vector; the block
// answers with one result: the projection v (taken before the update) and the
// four updated weights. After acceptance the block steps through the SUM, VW,
// TERM and UPD states, and the result lands in the output register as it leaves
// UPD; only then is the next sample taken, so samples never overlap. The pace
// is set by the chain of four dependent multiplies per lane (w*z, v*w,
// v*d, eta*t) with the lane sum in between, and by the weights feeding the
// next sample. A result waiting in the output register does not hold off the
// next sample, only the following update. Writing init_weightK loads weight K
// at once; learn_rate is unsigned Q0.16. Write registers only while idle.
// ----------------------------------------------------------------------------
`include "oja_rule_weight_update_top_defines.svh"

module oja_rule_weight_update_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  owu_pkg::sample_t     in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output owu_pkg::result_t     out_data,
    input  logic                 cfg_wr_en,
    input  owu_pkg::cfg_idx_t    cfg_index,
    input  owu_pkg::cfg_data_t   cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_VW,
        ST_TERM,
        ST_UPD
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic                out_valid_reg;
    owu_pkg::result_t    out_data_reg;
    owu_pkg::rate_t      learn_rate_reg;

    logic                in_fire;
    logic                done;
    owu_pkg::lane_ctrl_t ctrl;

    owu_pkg::value_t     samples    [owu_pkg::NUM_W];
    owu_pkg::prod_t      prods      [owu_pkg::NUM_W];
    owu_pkg::value_t     weights    [owu_pkg::NUM_W];
    owu_pkg::value_t     weight_upd [owu_pkg::NUM_W];
    owu_pkg::value_t     proj;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    // finish only when the output register is free or being emptied
    assign done     = (state_reg == ST_UPD) && (!out_valid_reg || !out_stall);

    assign ctrl.load_sample = in_fire;
    assign ctrl.calc_vw     = (state_reg == ST_VW);
    assign ctrl.calc_term   = (state_reg == ST_TERM);
    assign ctrl.update      = done;

    assign samples[0] = in_data.sample0;
    assign samples[1] = in_data.sample1;
    assign samples[2] = in_data.sample2;
    assign samples[3] = in_data.sample3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg <= owu_pkg::LEARN_RATE_RESET;
        end
        else if (cfg_wr_en && (cfg_index == owu_pkg::REG_LEARN_RATE))
        begin
            learn_rate_reg <= cfg_data[owu_pkg::RATE_BITS-1:0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < owu_pkg::NUM_W; k++)
        begin : g_lane
            owu_lane u_lane
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .sample     (samples[k]),
                .proj       (proj),
                .learn_rate (learn_rate_reg),
                .load_en    (cfg_wr_en && (cfg_index ==
                             owu_pkg::cfg_idx_t'(owu_pkg::REG_INIT_WEIGHT0 + k))),
                .load_val   (cfg_data[owu_pkg::VALUE_WIDTH-1:0]),
                .prod       (prods[k]),
                .weight     (weights[k]),
                .weight_upd (weight_upd[k])
            );
        end
    endgenerate

    owu_merge u_merge
    (
        .clk  (clk),
        .en   (state_reg == ST_SUM),
        .prod (prods),
        .proj (proj)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_SUM;
            ST_SUM:  state_next = ST_VW;
            ST_VW:   state_next = ST_TERM;
            ST_TERM: state_next = ST_UPD;
            ST_UPD:  if (done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (done)
            begin
                out_valid_reg            <= 1'b1;
                out_data_reg.projection  <= proj;
                out_data_reg.weight_out0 <= weight_upd[0];
                out_data_reg.weight_out1 <= weight_upd[1];
                out_data_reg.weight_out2 <= weight_upd[2];
                out_data_reg.weight_out3 <= weight_upd[3];
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `OWU_ASSERT_NEXT(a_accept_starts_sum, clk, rst_n, in_fire, state_reg == ST_SUM)
    `OWU_ASSERT_NEXT(a_done_fills_output, clk, rst_n, done, out_valid_reg && (state_reg == ST_IDLE))
    `OWU_ASSERT_NEXT(a_weights_hold_mid, clk, rst_n, (state_reg == ST_VW) && !cfg_wr_en, $stable(weights[0]) && $stable(weights[3]))

endmodule
